// ===== hw/rtl/sorted_record_table_macros.svh =====
// Assertion macros shared by the checker of the sorted record table.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SORTED_RECORD_TABLE_MACROS_SVH
`define SORTED_RECORD_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/srt_pkg.sv =====
// Types and codes of the sorted record table.
// No dependencies; used by the controller, the datapath and the top level.
package srt_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_DUP     = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EVAL   = 2'd1,
        S_COMMIT = 2'd2
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic    capture;
        logic    eval;
        logic    commit;
        t_op     op;
        t_status status;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        t_action action;
        logic    hit_any;
        logic    full;
        logic    pos_ok;
    } t_stat;

endpackage

// ===== hw/rtl/srt_ctrl.sv =====
// Controller of the sorted record table: sequences capture, evaluate and commit,
// picks the status code and owns the output valid. Depends on srt_pkg.
module srt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  srt_pkg::t_stat i_stat,
    output srt_pkg::t_cmd  o_cmd
);

    srt_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srt_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.op     = srt_pkg::OP_NONE;
        o_cmd.status = srt_pkg::ST_DONE;

        unique case (r_state)
            srt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = srt_pkg::S_EVAL;
                end
            end
            srt_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = srt_pkg::S_COMMIT;
            end
            srt_pkg::S_COMMIT: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    unique case (i_stat.action)
                        srt_pkg::ACT_INSERT: begin
                            priority if (i_stat.hit_any) begin
                                o_cmd.status = srt_pkg::ST_DUP;
                            end else if (i_stat.full) begin
                                o_cmd.status = srt_pkg::ST_FULL;
                            end else begin
                                o_cmd.op = srt_pkg::OP_INSERT;
                            end
                        end
                        srt_pkg::ACT_REMOVE: begin
                            if (i_stat.hit_any) begin
                                o_cmd.op = srt_pkg::OP_REMOVE;
                            end else begin
                                o_cmd.status = srt_pkg::ST_MISSING;
                            end
                        end
                        srt_pkg::ACT_READ: begin
                            if (i_stat.pos_ok) begin
                                o_cmd.op = srt_pkg::OP_READ;
                            end else begin
                                o_cmd.status = srt_pkg::ST_MISSING;
                            end
                        end
                        default: begin
                            o_cmd.op = srt_pkg::OP_NONE;
                        end
                    endcase
                    // take the next item in the same cycle the result is loaded
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.capture = 1'b1;
                        n_state       = srt_pkg::S_EVAL;
                    end else begin
                        n_state = srt_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = srt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

// ===== hw/rtl/srt_datapath.sv =====
// Datapath of the sorted record table: the row of record cells, the compare
// vectors, the grouped read tree and the result register. Depends on srt_pkg.
module srt_datapath #(
    parameter int DEPTH     = 64,
    parameter int FLOW_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  srt_pkg::t_cmd  i_cmd,
    output srt_pkg::t_stat o_stat,
    input  logic [1:0]     i_action,
    input  logic [15:0]    i_year_key,
    input  logic [31:0]    i_flow_value,
    input  logic [5:0]     i_position,
    output logic [1:0]     o_status,
    output logic [6:0]     o_entry_count,
    output logic [15:0]    o_read_year,
    output logic [31:0]    o_read_flow
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int GRP   = 8;
    localparam int NGRP  = (DEPTH + GRP - 1) / GRP;

    // record cells
    logic [15:0]          r_year [DEPTH];
    logic [FLOW_BITS-1:0] r_flow [DEPTH];
    logic [15:0]          n_year [DEPTH];
    logic [FLOW_BITS-1:0] n_flow [DEPTH];
    logic [CNT_W-1:0]     r_count, n_count;

    // captured item
    srt_pkg::t_action     r_act;
    logic [15:0]          r_key;
    logic [FLOW_BITS-1:0] r_fin;
    logic [5:0]           r_pos;

    // evaluate stage
    logic [DEPTH-1:0]     r_hit, w_hit;
    logic [DEPTH-1:0]     r_ge, w_ge;
    logic [DEPTH-1:0]     w_sel;
    logic                 r_pos_ok, w_pos_ok;
    logic [15:0]          r_gyear [NGRP];
    logic [FLOW_BITS-1:0] r_gflow [NGRP];
    logic [15:0]          w_gyear [NGRP];
    logic [FLOW_BITS-1:0] w_gflow [NGRP];

    // neighbor views of the cells
    logic [15:0]          w_year_up [DEPTH];
    logic [FLOW_BITS-1:0] w_flow_up [DEPTH];
    logic [15:0]          w_year_dn [DEPTH];
    logic [FLOW_BITS-1:0] w_flow_dn [DEPTH];
    logic [DEPTH-1:0]     w_ge_prev;
    logic [DEPTH-1:0]     w_after;

    logic [15:0]          w_rd_year;
    logic [FLOW_BITS-1:0] w_rd_flow;

    // result register
    logic [1:0]           r_o_status;
    logic [6:0]           r_o_count;
    logic [15:0]          r_o_year;
    logic [31:0]          r_o_flow;

    assign o_stat.action  = r_act;
    assign o_stat.hit_any = |r_hit;
    assign o_stat.full    = (r_count == CNT_W'(DEPTH));
    assign o_stat.pos_ok  = r_pos_ok;

    assign o_status      = r_o_status;
    assign o_entry_count = r_o_count;
    assign o_read_year   = r_o_year;
    assign o_read_flow   = r_o_flow;

    // compare every cell against the captured item
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_hit[i] = (i < int'(r_count)) && (r_year[i] == r_key);
            w_ge[i]  = (i < int'(r_count)) && (r_flow[i] >= r_fin);
            w_sel[i] = (i == int'(r_pos));
        end
        w_pos_ok = int'(r_pos) < int'(r_count);
    end

    // first level of the read tree: one partial result per group of cells
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_gyear[g] = '0;
            w_gflow[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                if ((g * GRP + k) < DEPTH) begin
                    if (w_sel[g * GRP + k]) begin
                        w_gyear[g] = w_gyear[g] | r_year[g * GRP + k];
                        w_gflow[g] = w_gflow[g] | r_flow[g * GRP + k];
                    end
                end
            end
        end
    end

    // second level of the read tree
    always_comb begin
        w_rd_year = '0;
        w_rd_flow = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_rd_year = w_rd_year | r_gyear[g];
            w_rd_flow = w_rd_flow | r_gflow[g];
        end
    end

    always_comb begin
        w_year_up[0]       = r_year[0];
        w_flow_up[0]       = r_flow[0];
        w_year_dn[DEPTH-1] = '0;
        w_flow_dn[DEPTH-1] = '0;
        for (int i = 1; i < DEPTH; i++) begin
            w_year_up[i]   = r_year[i-1];
            w_flow_up[i]   = r_flow[i-1];
            w_year_dn[i-1] = r_year[i];
            w_flow_dn[i-1] = r_flow[i];
        end
    end

    // ge is a suffix of the valid cells, so the shift region starts one past it
    assign w_ge_prev = {r_ge[DEPTH-2:0], 1'b0};
    // hit is one-hot on a remove: mark the hit cell and all above it
    assign w_after   = ~(r_hit - DEPTH'(1));

    always_comb begin
        n_count = r_count;
        for (int i = 0; i < DEPTH; i++) begin
            n_year[i] = r_year[i];
            n_flow[i] = r_flow[i];
        end
        if (i_cmd.commit) begin
            unique case (i_cmd.op)
                srt_pkg::OP_INSERT: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (w_ge_prev[i]) begin
                            n_year[i] = w_year_up[i];
                            n_flow[i] = w_flow_up[i];
                        end else if (r_ge[i] || (i == int'(r_count))) begin
                            n_year[i] = r_key;
                            n_flow[i] = r_fin;
                        end
                    end
                    n_count = r_count + CNT_W'(1);
                end
                srt_pkg::OP_REMOVE: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (w_after[i]) begin
                            n_year[i] = w_year_dn[i];
                            n_flow[i] = w_flow_dn[i];
                        end
                    end
                    n_count = r_count - CNT_W'(1);
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_year[i] <= n_year[i];
            r_flow[i] <= n_flow[i];
        end
        if (i_cmd.capture) begin
            r_act <= srt_pkg::t_action'(i_action);
            r_key <= i_year_key;
            r_fin <= FLOW_BITS'(i_flow_value);
            r_pos <= i_position;
        end
        if (i_cmd.eval) begin
            r_hit    <= w_hit;
            r_ge     <= w_ge;
            r_pos_ok <= w_pos_ok;
            for (int g = 0; g < NGRP; g++) begin
                r_gyear[g] <= w_gyear[g];
                r_gflow[g] <= w_gflow[g];
            end
        end
        if (i_cmd.commit) begin
            r_o_status <= i_cmd.status;
            r_o_count  <= 7'(n_count);
            if (i_cmd.op == srt_pkg::OP_READ) begin
                r_o_year <= w_rd_year;
                r_o_flow <= 32'(w_rd_flow);
            end else begin
                r_o_year <= '0;
                r_o_flow <= '0;
            end
        end
    end

endmodule

// ===== hw/rtl/sorted_record_table.sv =====
// Top level of the sorted record table: a controller and a datapath.
// Depends on srt_pkg, srt_ctrl and srt_datapath.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_ready    i_action i_year_key i_flow_value
//                                                   i_position
//   output    out        o_out_valid / i_out_ready  o_status o_entry_count o_read_year
//                                                   o_read_flow
//
// An accepted item is evaluated (all cells compared in parallel, read tree first
// level registered), then committed to the result register.
// The next item is taken in the commit cycle of the item before it.
// Reset empties the table; no clearing pass is needed.
// A result held by a low i_out_ready stalls the commit and the input with it.
module sorted_record_table #(
    parameter int DEPTH     = 64,
    parameter int FLOW_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_year_key,
    input  logic [31:0] i_flow_value,
    input  logic [5:0]  i_position,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [6:0]  o_entry_count,
    output logic [15:0] o_read_year,
    output logic [31:0] o_read_flow
);

    srt_pkg::t_cmd  w_cmd;
    srt_pkg::t_stat w_stat;

    srt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    srt_datapath #(
        .DEPTH     (DEPTH),
        .FLOW_BITS (FLOW_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_action      (i_action),
        .i_year_key    (i_year_key),
        .i_flow_value  (i_flow_value),
        .i_position    (i_position),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_read_year   (o_read_year),
        .o_read_flow   (o_read_flow)
    );

endmodule

// ===== hw/rtl/srt_checker.sv =====
// Port-level checker of the sorted record table and its bind to the top level.
// Depends on sorted_record_table_macros.svh and srt_pkg.
`include "sorted_record_table_macros.svh"

module srt_checker #(
    parameter int DEPTH = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_action,
    input logic [15:0] i_year_key,
    input logic [31:0] i_flow_value,
    input logic [5:0]  i_position,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [6:0]  o_entry_count,
    input logic [15:0] o_read_year,
    input logic [31:0] o_read_flow
);

    `SRT_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready,
        i_in_valid && $stable(i_action) && $stable(i_year_key)
        && $stable(i_flow_value) && $stable(i_position), "input item changed while waiting")

    `SRT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_status) && $stable(o_entry_count)
        && $stable(o_read_year) && $stable(o_read_flow), "result changed while stalled")

    `SRT_ASSERT_NOW(a_fail_no_data, i_clk, i_rst_n,
        o_out_valid && (o_status != srt_pkg::ST_DONE),
        (o_read_year == 16'd0) && (o_read_flow == 32'd0), "failed item carries read data")

    `SRT_ASSERT_NOW(a_full_count, i_clk, i_rst_n,
        o_out_valid && (o_status == srt_pkg::ST_FULL),
        o_entry_count == 7'(DEPTH), "full status with count below depth")

    `SRT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_out_valid,
        (DEPTH > 127) || (int'(o_entry_count) <= DEPTH), "count above depth")

endmodule

bind sorted_record_table srt_checker #(.DEPTH(DEPTH)) u_srt_checker (.*);

// ===== dv/sorted_record_table_tb.sv =====
// Self-checking testbench of sorted_record_table: random and directed items with a scoreboard.
// The scoreboard keeps its own sorted copy of the table and predicts each result.
// Depends on srt_pkg and the sorted_record_table RTL.
`timescale 1ns / 100ps

module sorted_record_table_tb;

    localparam int TABLE_DEPTH = 64;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        srt_pkg::t_status status;
        logic [6:0]       count;
        logic [15:0]      year;
        logic [31:0]      flow;
    } t_table_result;

    // Sorted copy of the table and the queue of predicted results.
    class record_table_sb;
        logic [15:0]   years [TABLE_DEPTH];
        logic [31:0]   flows [TABLE_DEPTH];
        int            count;
        int            max_count;
        int            errors;
        t_table_result pending [$];

        function new();
            count     = 0;
            max_count = 0;
            errors    = 0;
        endfunction

        function void note_item(srt_pkg::t_action act, logic [15:0] y, logic [31:0] f,
                                logic [5:0] p);
            t_table_result r;
            int hit;
            int slot;
            r   = '0;
            hit = -1;
            for (int i = 0; i < count; i++) begin
                if (hit < 0 && years[i] == y) hit = i;
            end
            case (act)
                srt_pkg::ACT_INSERT: begin
                    if (hit >= 0) begin
                        r.status = srt_pkg::ST_DUP;
                    end else if (count >= TABLE_DEPTH) begin
                        r.status = srt_pkg::ST_FULL;
                    end else begin
                        // Go before the first flow that is greater or equal.
                        slot = 0;
                        while (slot < count && flows[slot] < f) slot++;
                        for (int i = count; i > slot; i--) begin
                            years[i] = years[i - 1];
                            flows[i] = flows[i - 1];
                        end
                        years[slot] = y;
                        flows[slot] = f;
                        count++;
                        if (count > max_count) max_count = count;
                    end
                end
                srt_pkg::ACT_REMOVE: begin
                    if (hit < 0) begin
                        r.status = srt_pkg::ST_MISSING;
                    end else begin
                        for (int i = hit; i + 1 < count; i++) begin
                            years[i] = years[i + 1];
                            flows[i] = flows[i + 1];
                        end
                        count--;
                    end
                end
                srt_pkg::ACT_READ: begin
                    if (p < count) begin
                        r.year = years[p];
                        r.flow = flows[p];
                    end else begin
                        r.status = srt_pkg::ST_MISSING;
                    end
                end
                default: begin
                end
            endcase
            r.count = count[6:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [6:0] n, logic [15:0] ry,
                                   logic [31:0] rf);
            t_table_result r;
            if (pending.size() == 0) begin
                $error("result with no item outstanding: status %0d count %0d", st, n);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (st !== r.status) begin
                $error("status: expected %0d, got %0d", r.status, st);
                errors++;
            end
            if (n !== r.count) begin
                $error("entry_count: expected %0d, got %0d", r.count, n);
                errors++;
            end
            if (ry !== r.year) begin
                $error("read_year: expected %h, got %h", r.year, ry);
                errors++;
            end
            if (rf !== r.flow) begin
                $error("read_flow: expected %h, got %h", r.flow, rf);
                errors++;
            end
        endfunction
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [1:0]  action     = 2'd0;
    logic [15:0] year_key   = 16'd0;
    logic [31:0] flow_value = 32'd0;
    logic [5:0]  position   = 6'd0;
    logic        out_ready  = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [1:0]  status;
    logic [6:0]  entry_count;
    logic [15:0] read_year;
    logic [31:0] read_flow;

    bit             calm = 1'b0;
    record_table_sb sb   = new();

    sorted_record_table dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_action      (action),
        .i_year_key    (year_key),
        .i_flow_value  (flow_value),
        .i_position    (position),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (status),
        .o_entry_count (entry_count),
        .o_read_year   (read_year),
        .o_read_flow   (read_flow)
    );

    always #6 clk = ~clk;

    // Check each result taken, then pick the next ready.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_result(status, entry_count, read_year, read_flow);
        end
        out_ready <= calm || ($urandom_range(99) >= 30);
    end

    task automatic send_item(srt_pkg::t_action a, logic [15:0] y, logic [31:0] f,
                             logic [5:0] p);
        while (!calm && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= a;
        year_key   <= y;
        flow_value <= f;
        position   <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_item(a, y, f, p);
    endtask

    // Hold the input until every predicted result has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_year();
        int r;
        r = $urandom_range(99);
        if (r < 50 && sb.count > 0) return sb.years[$urandom_range(sb.count - 1)];
        if (r < 80) return 16'($urandom_range(127));
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_flow();
        int r;
        r = $urandom_range(99);
        if (r < 40) return 32'($urandom_range(15));
        if (r < 50) return 32'd0;
        if (r < 60) return 32'hffff_ffff;
        return $urandom;
    endfunction

    task automatic random_item(int ins_pct, int rem_pct);
        srt_pkg::t_action a;
        logic [5:0] p;
        int r;
        r = $urandom_range(99);
        p = 6'($urandom);
        if (r < ins_pct) begin
            a = srt_pkg::ACT_INSERT;
        end else if (r < ins_pct + rem_pct) begin
            a = srt_pkg::ACT_REMOVE;
        end else if (r < 97) begin
            a = srt_pkg::ACT_READ;
            // Keep reads on entries that have been written at least once.
            if (sb.count > 0 && $urandom_range(99) < 75) begin
                p = 6'($urandom_range(sb.count - 1));
            end else if (sb.max_count > 0) begin
                p = 6'($urandom_range(sb.max_count - 1));
            end else begin
                a = srt_pkg::ACT_REMOVE;
            end
        end else begin
            a = srt_pkg::ACT_NOP;
        end
        send_item(a, pick_year(), pick_flow(), p);
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes, equal flows, duplicates, reads, removes.
        send_item(srt_pkg::ACT_REMOVE, 16'd0, 32'd0, 6'd0);
        send_item(srt_pkg::ACT_INSERT, 16'd0, 32'd0, 6'd0);
        send_item(srt_pkg::ACT_INSERT, 16'd0, 32'd5, 6'd0);
        send_item(srt_pkg::ACT_INSERT, 16'hffff, 32'hffff_ffff, 6'h3f);
        send_item(srt_pkg::ACT_INSERT, 16'd1234, 32'd0, 6'd0);
        send_item(srt_pkg::ACT_INSERT, 16'd2000, 32'h8000_0000, 6'd0);
        send_item(srt_pkg::ACT_INSERT, 16'd2001, 32'h8000_0000, 6'd0);
        send_item(srt_pkg::ACT_INSERT, 16'd1999, 32'h1234_5678, 6'd0);
        send_item(srt_pkg::ACT_INSERT, 16'hffff, 32'd1, 6'd0);
        for (int i = 0; i < 6; i++) begin
            send_item(srt_pkg::ACT_READ, 16'hffff, 32'hffff_ffff, 6'(i));
        end
        send_item(srt_pkg::ACT_REMOVE, 16'hffff, 32'd0, 6'h3f);
        send_item(srt_pkg::ACT_READ, 16'd0, 32'd0, 6'd5);
        send_item(srt_pkg::ACT_NOP, 16'hffff, 32'hffff_ffff, 6'h3f);
        send_item(srt_pkg::ACT_REMOVE, 16'd0, 32'd0, 6'd0);
        send_item(srt_pkg::ACT_REMOVE, 16'd7777, 32'd0, 6'd0);
        send_item(srt_pkg::ACT_READ, 16'd0, 32'd0, 6'd0);
        send_item(srt_pkg::ACT_READ, 16'd0, 32'd0, 6'd3);
        drain_results();

        // Fill up and sit at full.
        for (int i = 0; i < 600; i++) random_item(60, 20);
        drain_results();
        // Empty out, with many removes on an empty table.
        for (int i = 0; i < 600; i++) random_item(20, 55);
        drain_results();
        // Balanced, first stretch with no idling on either side.
        calm = 1'b1;
        for (int i = 0; i < 300; i++) random_item(40, 40);
        calm = 1'b0;
        for (int i = 0; i < 350; i++) random_item(40, 40);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending.size() != 0) begin
            $error("%0d results never came out", sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
